// ===== rtl/febm_pkg.sv =====
// package: constants, codes and types of the flash erase block manager
`timescale 1ns / 1ps
`default_nettype none
package febm_pkg;
	localparam int MaxBlocks = 1024;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = 11;
	localparam int DirtyW = 32;
	localparam int BytesW = 35;
	localparam int LenW = 25;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0, OP_MARK_USED = 3'd1, OP_ADD_DIRTY = 3'd2,
		OP_ERASE = 3'd3, OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NO_SPACE = 2'd1, ST_BAD_INDEX = 2'd2, ST_NOT_USED = 2'd3
	} status_t;

	localparam logic [1:0] ClsDelete = 2'd1;
	localparam logic [1:0] ClsGc = 2'd2;

	localparam logic [2:0] RegBlockCount = 3'd0;
	localparam logic [2:0] RegFirstBlock = 3'd1;
	localparam logic [2:0] RegReservedGc = 3'd2;
	localparam logic [2:0] RegReservedDel = 3'd3;
	localparam logic [2:0] RegBlockBytes = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/febm_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module febm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/flash_erase_block_manager_top.sv =====
// top level of the flash erase block manager
`timescale 1ns / 1ps
`default_nettype none
// Erase block manager. Block state (used bit plus 32-bit dirty counter) lives in one
// 1024x33 single-port ram with registered read. After reset and after every block_count
// write the ram is swept clear, one entry a cycle, while in_ready stays low.
// Mark used, add dirty and erase read the entry, then modify and write it back. Allocate
// scans from first_block one entry a cycle, if the reserve check passes, and stops at the
// first unused block; query always scans the whole range from first_block, with two
// multiply steps for the byte figures. One word is worked at a time; the result sits in
// an output register while the next word may already be accepted.
module flash_erase_block_manager_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  opcode,
	input  wire logic [febm_pkg::IdxW-1:0]   block_index,
	input  wire logic [febm_pkg::LenW-1:0]   dirty_length,
	input  wire logic [1:0]                  op_class,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [febm_pkg::IdxW-1:0]        current_block,
	output logic [febm_pkg::CntW-1:0]        free_count,
	output logic                             dirtiest_valid,
	output logic [febm_pkg::IdxW-1:0]        dirtiest_block,
	output logic [febm_pkg::BytesW-1:0]      free_bytes,
	output logic [febm_pkg::BytesW-1:0]      available_bytes,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [31:0]                 cfg_data
);
	import febm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_MOD, S_SCAN, S_SCAN_END, S_MUL1, S_MUL2, S_DONE
	} state_t;

	localparam int RamW = DirtyW + 1;

	state_t state_q;
	logic [CntW-1:0] block_count_q, res_gc_q, res_del_q, free_q;
	logic [IdxW-1:0] first_q, cur_q, addr_q, best_blk_q;
	logic [LenW-1:0] bsize_q;
	logic [2:0] op_q;
	logic [IdxW-1:0] idx_q;
	logic [LenW-1:0] len_q;
	logic [1:0] cls_q;
	logic [DirtyW-1:0] best_q;
	logic best_v_q, clr_req_q, scan_any_q;
	logic [CntW-1:0] unused_q;
	logic [BytesW-1:0] fb_q, resv_q;
	logic [CntW-1:0] lim_q; // scan limit
	status_t status_q;

	logic we;
	logic [IdxW-1:0] ram_addr;
	logic [RamW-1:0] wdata, rdata;
	logic out_v_q;
	logic out_load;
	logic r_used;
	logic [DirtyW-1:0] r_dirty;

	logic [CntW-1:0] lim;
	assign lim = (block_count_q > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : block_count_q;
	assign r_used = rdata[DirtyW];
	assign r_dirty = rdata[DirtyW-1:0];

	// a new word may enter whenever the engine is idle and no clear is pending
	assign in_ready = (state_q == S_IDLE) && !clr_req_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	// result register loads when empty or while its word is taken
	assign out_load = (state_q == S_DONE) && (!out_v_q || out_ready);

	febm_ram #(.Width(RamW), .Depth(MaxBlocks)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
	);

	// reserve check on the free counter
	logic res_ok;
	always_comb begin
		if (cls_q == ClsGc) res_ok = 1'b1;
		else if (free_q < res_gc_q) res_ok = 1'b0;
		else if (cls_q == ClsDelete) res_ok = 1'b1;
		else res_ok = {1'b0, free_q} >= ({1'b0, res_gc_q} + {1'b0, res_del_q});
	end

	logic idx_ok;
	assign idx_ok = (idx_q >= first_q) && ({1'b0, idx_q} < lim_q);

	// dirty add with saturation
	logic [DirtyW:0] dsum;
	assign dsum = {1'b0, r_dirty} + (DirtyW+1)'(len_q);

	// scan position is one ahead of the data: rdata belongs to addr_q - 1
	logic [IdxW-1:0] prev_addr;
	assign prev_addr = addr_q - IdxW'(1);

	always_comb begin
		we = 1'b0;
		wdata = '0;
		ram_addr = addr_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_RD: ram_addr = idx_q;
			S_MOD: begin
				ram_addr = idx_q;
				case (op_q)
					OP_MARK_USED: begin
						we = idx_ok;
						wdata = {1'b1, r_dirty};
					end
					OP_ADD_DIRTY: begin
						we = idx_ok && r_used;
						wdata = {1'b1, dsum[DirtyW] ? {DirtyW{1'b1}} : dsum[DirtyW-1:0]};
					end
					OP_ERASE: begin
						we = idx_ok && r_used;
						wdata = '0;
					end
					default: we = 1'b0;
				endcase
			end
			S_SCAN: begin
				// allocate: take the block just read if unused
				if (op_q == OP_ALLOC && scan_any_q && !r_used) begin
					we = 1'b1;
					ram_addr = prev_addr;
					wdata = {1'b1, r_dirty};
				end
			end
			S_SCAN_END: begin
				// allocate: last entry of the range
				if (op_q == OP_ALLOC && !r_used) begin
					we = 1'b1;
					ram_addr = prev_addr;
					wdata = {1'b1, r_dirty};
				end
			end
			default: ;
		endcase
	end

	logic [CntW:0] resv_sum;
	assign resv_sum = {1'b0, res_gc_q} + {1'b0, res_del_q};
	logic [CntW+LenW:0] resv_prod;
	assign resv_prod = (CntW+LenW+1)'(resv_sum) * (CntW+LenW+1)'(bsize_q);
	logic [CntW+LenW-1:0] fb_prod;
	assign fb_prod = (CntW+LenW)'(unused_q) * (CntW+LenW)'(bsize_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			block_count_q <= CntW'(1024);
			first_q <= IdxW'(1);
			res_gc_q <= '0;
			res_del_q <= '0;
			bsize_q <= LenW'(131072);
			free_q <= CntW'(1024);
			cur_q <= '0;
			addr_q <= '0;
			clr_req_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					RegBlockCount: begin
						block_count_q <= cfg_data[CntW-1:0];
						free_q <= cfg_data[CntW-1:0];
						cur_q <= '0;
						clr_req_q <= 1'b1;
					end
					RegFirstBlock: first_q <= cfg_data[IdxW-1:0];
					RegReservedGc: res_gc_q <= cfg_data[CntW-1:0];
					RegReservedDel: res_del_q <= cfg_data[CntW-1:0];
					RegBlockBytes: bsize_q <= cfg_data[LenW-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + IdxW'(1);
					if (addr_q == IdxW'(MaxBlocks-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (clr_req_q && !cfg_valid) begin
						clr_req_q <= 1'b0;
						addr_q <= '0;
						state_q <= S_CLEAR;
					end else if (in_valid && in_ready) begin
						op_q <= opcode;
						idx_q <= block_index;
						len_q <= dirty_length;
						cls_q <= op_class;
						lim_q <= lim;
						best_q <= '0;
						best_v_q <= 1'b0;
						best_blk_q <= '0;
						unused_q <= '0;
						fb_q <= '0;
						resv_q <= '0;
						scan_any_q <= 1'b0;
						addr_q <= first_q;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					case (op_q)
						OP_ALLOC: begin
							cur_q <= '0;
							status_q <= ST_NO_SPACE;
							state_q <= (res_ok && {1'b0, first_q} < lim_q) ?
								S_SCAN : S_DONE;
						end
						OP_QUERY: begin
							status_q <= ST_OK;
							state_q <= ({1'b0, first_q} < lim_q) ? S_SCAN : S_MUL1;
						end
						OP_MARK_USED, OP_ADD_DIRTY, OP_ERASE: begin
							status_q <= ST_OK;
							state_q <= S_MOD;
						end
						default: begin
							status_q <= ST_OK;
							state_q <= S_DONE;
						end
					endcase
					if (op_q == OP_ALLOC || op_q == OP_QUERY) addr_q <= first_q;
				end
				S_MOD: begin
					if (!idx_ok) status_q <= ST_BAD_INDEX;
					else if (op_q == OP_MARK_USED) begin
						if (free_q != '0) free_q <= free_q - CntW'(1);
					end else if (!r_used) status_q <= ST_NOT_USED;
					else if (op_q == OP_ERASE && free_q != CntW'(2047))
						free_q <= free_q + CntW'(1);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// issue read at addr_q, look at data of addr_q - 1
					scan_any_q <= 1'b1;
					if (scan_any_q) begin
						if (op_q == OP_ALLOC) begin
							if (!r_used) begin
								cur_q <= prev_addr;
								status_q <= ST_OK;
								if (free_q != '0) free_q <= free_q - CntW'(1);
								state_q <= S_DONE;
							end
						end else if (!r_used) unused_q <= unused_q + CntW'(1);
						else if (prev_addr != cur_q && r_dirty > best_q) begin
							best_q <= r_dirty;
							best_blk_q <= prev_addr;
							best_v_q <= 1'b1;
						end
					end
					if (!(scan_any_q && op_q == OP_ALLOC && !r_used)) begin
						if ({1'b0, addr_q} + (IdxW+1)'(1) >= (IdxW+1)'(lim_q) ||
						    addr_q == IdxW'(MaxBlocks-1))
							state_q <= S_SCAN_END;
						addr_q <= addr_q + IdxW'(1);
					end
				end
				S_SCAN_END: begin
					// last entry's data
					if (op_q == OP_ALLOC) begin
						if (!r_used) begin
							cur_q <= prev_addr;
							status_q <= ST_OK;
							if (free_q != '0) free_q <= free_q - CntW'(1);
						end
						state_q <= S_DONE;
					end else begin
						if (!r_used) unused_q <= unused_q + CntW'(1);
						else if (prev_addr != cur_q && r_dirty > best_q) begin
							best_q <= r_dirty;
							best_blk_q <= prev_addr;
							best_v_q <= 1'b1;
						end
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					fb_q <= BytesW'(fb_prod);
					resv_q <= (resv_prod[CntW+LenW:BytesW] != '0) ?
						{BytesW{1'b1}} : resv_prod[BytesW-1:0];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						status <= status_q;
						current_block <= cur_q;
						free_count <= free_q;
						dirtiest_valid <= (op_q == OP_QUERY) && best_v_q;
						dirtiest_block <= (op_q == OP_QUERY) ? best_blk_q : '0;
						free_bytes <= (op_q == OP_QUERY) ? fb_q : '0;
						available_bytes <= (op_q == OP_QUERY && fb_q >= resv_q) ?
							fb_q - resv_q : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready) else $error("input during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (status_q != ST_OK || op_q != OP_ALLOC || cur_q >= first_q))
		else $error("allocated below first block");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the flash erase block manager
`timescale 1ns / 1ps
module tb;
	import febm_pkg::*;

	// class codes the package leaves out
	localparam logic [1:0] ClsNormal = 2'd0;
	localparam logic [1:0] ClsSpare = 2'd3;
	// opcodes above query do nothing and still answer ok
	localparam logic [2:0] OpSpare5 = 3'd5;
	localparam logic [2:0] OpSpare6 = 3'd6;
	localparam logic [2:0] OpSpare7 = 3'd7;
	localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
	localparam logic [BytesW-1:0] BytesSat = {BytesW{1'b1}};

	typedef struct packed {
		logic [1:0]        status;
		logic [IdxW-1:0]   cur;
		logic [CntW-1:0]   free;
		logic              dvalid;
		logic [IdxW-1:0]   dblock;
		logic [BytesW-1:0] fbytes;
		logic [BytesW-1:0] abytes;
	} result_t;

	// one directed word; when typed is set the expected status, current block and free
	// count are given by hand and the query fields are zero
	typedef struct packed {
		logic [2:0]      op;
		logic [IdxW-1:0] idx;
		logic [LenW-1:0] len;
		logic [1:0]      cls;
		logic            typed;
		logic [1:0]      t_status;
		logic [IdxW-1:0] t_cur;
		logic [CntW-1:0] t_free;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [IdxW-1:0] block_index = '0;
	logic [LenW-1:0] dirty_length = '0;
	logic [1:0] op_class = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [IdxW-1:0] current_block;
	logic [CntW-1:0] free_count;
	logic dirtiest_valid;
	logic [IdxW-1:0] dirtiest_block;
	logic [BytesW-1:0] free_bytes;
	logic [BytesW-1:0] available_bytes;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	flash_erase_block_manager_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .block_index(block_index),
		.dirty_length(dirty_length), .op_class(op_class),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .current_block(current_block), .free_count(free_count),
		.dirtiest_valid(dirtiest_valid), .dirtiest_block(dirtiest_block),
		.free_bytes(free_bytes), .available_bytes(available_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the block table and the registers
	logic        blk_used [MaxBlocks];
	logic [31:0] blk_dirt [MaxBlocks];
	int unsigned blk_free;
	int unsigned blk_cur;
	int unsigned n_blocks;
	int unsigned first_blk;
	int unsigned resv_gc;
	int unsigned resv_del;
	int unsigned blk_size;

	result_t expected_results[$];
	int errors = 0;
	bit quiet = 0;	// no idling on either side once set
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling, far above the slowest correct run
	initial begin
		#40_000_000;
		$display("tb: errors");
		$finish;
	end

	function automatic int unsigned scan_end();
		return (n_blocks < MaxBlocks) ? n_blocks : MaxBlocks;
	endfunction

	// wipe the table and reload the free counter, as reset and a block_count write do
	function automatic void wipe_table();
		for (int i = 0; i < MaxBlocks; i++) begin
			blk_used[i] = 1'b0;
			blk_dirt[i] = '0;
		end
		blk_free = n_blocks;
		blk_cur = 0;
	endfunction

	function automatic bit reserve_pass(logic [1:0] cls);
		if (cls == ClsGc)
			return 1;
		if (blk_free < resv_gc)
			return 0;
		if (cls == ClsDelete)
			return 1;
		return blk_free >= resv_gc + resv_del;
	endfunction

	// apply one word to the shadow table and return the answer it should give
	function automatic result_t manage_blocks(logic [2:0] op, logic [IdxW-1:0] idx,
			logic [LenW-1:0] len, logic [1:0] cls);
		result_t r;
		int unsigned lim;
		int unsigned unused;
		logic [31:0] best;
		logic [63:0] fb;
		logic [63:0] rsv;
		logic [32:0] sum;
		bit in_range;
		r = '0;
		lim = scan_end();
		in_range = (idx >= first_blk) && (idx < lim);
		case (op)
			OP_ALLOC: begin
				blk_cur = 0;
				r.status = ST_NO_SPACE;
				if (reserve_pass(cls)) begin
					for (int i = first_blk; i < lim; i++) begin
						if (!blk_used[i]) begin
							blk_used[i] = 1'b1;
							if (blk_free > 0)
								blk_free--;
							blk_cur = i;
							r.status = ST_OK;
							break;
						end
					end
				end
			end
			OP_MARK_USED: begin
				if (!in_range)
					r.status = ST_BAD_INDEX;
				else begin
					// a used block stays used, the counter still drops
					blk_used[idx] = 1'b1;
					if (blk_free > 0)
						blk_free--;
				end
			end
			OP_ADD_DIRTY: begin
				if (!in_range)
					r.status = ST_BAD_INDEX;
				else if (!blk_used[idx])
					r.status = ST_NOT_USED;
				else begin
					sum = {1'b0, blk_dirt[idx]} + 33'(len);
					blk_dirt[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			OP_ERASE: begin
				if (!in_range)
					r.status = ST_BAD_INDEX;
				else if (!blk_used[idx])
					r.status = ST_NOT_USED;
				else begin
					blk_used[idx] = 1'b0;
					blk_dirt[idx] = '0;
					if (blk_free < 2047)
						blk_free++;
				end
			end
			OP_QUERY: begin
				unused = 0;
				best = '0;
				for (int i = first_blk; i < lim; i++) begin
					if (!blk_used[i])
						unused++;
					else if (i != blk_cur && blk_dirt[i] > best) begin
						best = blk_dirt[i];
						r.dblock = IdxW'(i);
						r.dvalid = 1'b1;
					end
				end
				fb = 64'(unused) * 64'(blk_size);
				if (fb > 64'(BytesSat))
					fb = 64'(BytesSat);
				rsv = 64'(resv_gc + resv_del) * 64'(blk_size);
				r.fbytes = fb[BytesW-1:0];
				r.abytes = (fb < rsv) ? '0 : BytesW'(fb - rsv);
			end
			default: ;	// spare opcodes leave everything alone
		endcase
		r.cur = blk_cur[IdxW-1:0];
		r.free = blk_free[CntW-1:0];
		return r;
	endfunction

	// send one word, waiting for the handshake, and queue its expected answer
	task automatic send_word(stim_row_t w);
		result_t exp;
		in_valid <= 1'b1;
		opcode <= w.op;
		block_index <= w.idx;
		dirty_length <= w.len;
		op_class <= w.cls;
		do @(posedge clk); while (!in_ready);
		exp = manage_blocks(w.op, w.idx, w.len, w.cls);
		if (w.typed) begin
			exp = '0;
			exp.status = w.t_status;
			exp.cur = w.t_cur;
			exp.free = w.t_free;
		end
		expected_results.push_back(exp);
		// random sender gap
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] ri, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ri)
			RegBlockCount: begin
				n_blocks = val & 32'h7FF;
				wipe_table();
			end
			RegFirstBlock: first_blk = val & 32'h3FF;
			RegReservedGc: resv_gc = val & 32'h7FF;
			RegReservedDel: resv_del = val & 32'h7FF;
			RegBlockBytes: blk_size = val & 32'h1FF_FFFF;
			default: ;
		endcase
	endtask

	// wait for every answer, then idle before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [IdxW-1:0] pick_index();
		int unsigned lim;
		lim = scan_end();
		// mostly blocks in range so that words get past the index check
		if (lim > first_blk && $urandom_range(0, 99) < 85)
			return IdxW'($urandom_range(first_blk, lim - 1));
		return IdxW'($urandom_range(0, MaxBlocks - 1));
	endfunction

	function automatic stim_row_t random_word();
		stim_row_t w;
		int unsigned pick;
		w = '0;
		pick = $urandom_range(0, 99);
		w.idx = pick_index();
		w.cls = 2'($urandom_range(0, 3));
		w.len = $urandom_range(0, 3) == 0 ? LenMax : LenW'($urandom);
		if ($urandom_range(0, 2) == 0)
			w.len = LenW'($urandom_range(0, 4096));
		if (pick < 25)
			w.op = OP_ALLOC;
		else if (pick < 40)
			w.op = OP_MARK_USED;
		else if (pick < 65)
			w.op = OP_ADD_DIRTY;
		else if (pick < 80)
			w.op = OP_ERASE;
		else if (pick < 96)
			w.op = OP_QUERY;
		else
			w.op = 3'($urandom_range(OpSpare5, OpSpare7));
		return w;
	endfunction

	// result side: random stall bursts and the comparison against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t exp;
		if (out_valid && out_ready) begin
			got = '{status, current_block, free_count, dirtiest_valid, dirtiest_block,
				free_bytes, available_bytes};
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected word %p", got);
			end else begin
				exp = expected_results.pop_front();
				if (got !== exp) begin
					errors++;
					if (errors <= 10)
						$display("tb: mismatch\n  exp %p\n  got %p", exp, got);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// directed words under the reset settings (1024 blocks, first block 1, no reserve)
	stim_row_t directed [] = '{
		// first allocate of each class takes the lowest free blocks
		'{OP_ALLOC, 10'd0, 25'd0, ClsNormal, 1'b1, ST_OK, 10'd1, 11'd1023},
		'{OP_ALLOC, 10'd0, 25'd0, ClsDelete, 1'b1, ST_OK, 10'd2, 11'd1022},
		// block 0 lies under first_block
		'{OP_MARK_USED, 10'd0, 25'd0, ClsNormal, 1'b1, ST_BAD_INDEX, 10'd2, 11'd1022},
		'{OP_MARK_USED, 10'd1023, 25'd0, ClsNormal, 1'b1, ST_OK, 10'd2, 11'd1021},
		// dirt on a block never used
		'{OP_ADD_DIRTY, 10'd5, 25'd9, ClsNormal, 1'b1, ST_NOT_USED, 10'd2, 11'd1021},
		'{OP_ADD_DIRTY, 10'd1, LenMax, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		'{OP_ADD_DIRTY, 10'd1023, 25'd1000, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		// the current block never counts as dirtiest
		'{OP_ADD_DIRTY, 10'd2, LenMax, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		'{OP_QUERY, 10'd0, 25'd0, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		'{OP_ERASE, 10'd1023, 25'd0, ClsNormal, 1'b1, ST_OK, 10'd2, 11'd1022},
		'{OP_ERASE, 10'd1023, 25'd0, ClsNormal, 1'b1, ST_NOT_USED, 10'd2, 11'd1022},
		'{OP_ERASE, 10'd0, 25'd0, ClsNormal, 1'b1, ST_BAD_INDEX, 10'd2, 11'd1022},
		// used again: counter still drops
		'{OP_MARK_USED, 10'd1, 25'd0, ClsNormal, 1'b1, ST_OK, 10'd2, 11'd1021},
		'{OpSpare5, 10'h3FF, LenMax, ClsSpare, 1'b1, ST_OK, 10'd2, 11'd1021},
		'{OpSpare6, 10'd0, 25'd0, ClsNormal, 1'b1, ST_OK, 10'd2, 11'd1021},
		'{OpSpare7, 10'd7, 25'd0, ClsGc, 1'b1, ST_OK, 10'd2, 11'd1021},
		// class three behaves as normal
		'{OP_ALLOC, 10'd0, 25'd0, ClsSpare, 1'b1, ST_OK, 10'd3, 11'd1020},
		'{OP_ALLOC, 10'd0, 25'd0, ClsGc, 1'b1, ST_OK, 10'd4, 11'd1019},
		'{OP_QUERY, 10'd0, 25'd0, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		'{OP_ERASE, 10'd1, 25'd0, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0},
		'{OP_QUERY, 10'd0, 25'd0, ClsNormal, 1'b0, 2'd0, 10'd0, 11'd0}
	};

	// register settings per phase: block_count, first_block, reserved_gc,
	// reserved_delete, block_bytes; most are small to keep scans short
	int unsigned phases [8][5] = '{
		'{16, 1, 2, 3, 4096},
		'{8, 0, 0, 0, 32'h1FF_FFFF},
		'{2047, 0, 2047, 2047, 32'h1FF_FFFF},
		'{0, 0, 0, 0, 0},
		'{40, 1023, 1, 1, 100},
		'{24, 2, 5, 0, 7},
		'{1024, 1, 0, 0, 131072},
		'{12, 3, 1, 2, 1}
	};
	int phase_words [8] = '{100, 100, 40, 35, 45, 100, 50, 89};

	initial begin
		n_blocks = 1024;
		first_blk = 1;
		resv_gc = 0;
		resv_del = 0;
		blk_size = 131072;
		wipe_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_word(directed[i]);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_reg(RegFirstBlock, phases[p][1]);
			write_reg(RegReservedGc, phases[p][2]);
			write_reg(RegReservedDel, phases[p][3]);
			write_reg(RegBlockBytes, phases[p][4]);
			write_reg(RegBlockCount, phases[p][0]);
			// the last phase runs with no idling on either side
			if (p == 7)
				quiet = 1;
			for (int k = 0; k < phase_words[p]; k++)
				send_word(random_word());
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
